FILE: hw/rtl/les_pkg.sv
// les_pkg: shared types, codes and constants for the LED effect sequencer.
// Used by les_step and led_effect_sequencer; no dependencies.
`default_nettype none

package les_pkg;

  localparam int LED_COUNT = 12;
  localparam int IDX_W     = $clog2(LED_COUNT);
  localparam int OUT_LEDS  = 12;
  localparam int CNT_W     = 16;
  localparam int STEP_W    = 4;
  localparam int REP_W     = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 3;
  localparam int MODE_W    = 2;
  localparam int NOTE_W    = 7;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_MODE    = 3'd1;
  localparam logic [OP_W-1:0] OP_NOTE    = 3'd2;
  localparam logic [OP_W-1:0] OP_CORRECT = 3'd3;
  localparam logic [OP_W-1:0] OP_MISS    = 3'd4;

  localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHASE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHASE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_FLASH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_ON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_REPS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE        = 3'd5;

  localparam logic [CNT_W-1:0] RST_CHASE_PERIOD = 16'd100;
  localparam logic [CNT_W-1:0] RST_LOAD_FLASH   = 16'd500;
  localparam logic [CNT_W-1:0] RST_FLASH_PERIOD = 16'd600;
  localparam logic [CNT_W-1:0] RST_FLASH_ON     = 16'd300;
  localparam logic [REP_W-1:0] RST_FLASH_REPS   = 4'd3;
  localparam logic [CNT_W-1:0] RST_PULSE        = 16'd200;

  typedef struct packed {
    logic [CNT_W-1:0] chase_period_ms;
    logic [CNT_W-1:0] load_flash_ms;
    logic [CNT_W-1:0] flash_period_ms;
    logic [CNT_W-1:0] flash_on_ms;
    logic [REP_W-1:0] flash_repeats;
    logic [CNT_W-1:0] pulse_ms;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] new_mode;
    logic [NOTE_W-1:0] note_number;
    logic              note_on;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [CNT_W-1:0]     effect_elapsed;
    logic [CNT_W-1:0]     flash_phase;
    logic [STEP_W-1:0]    effect_step;
    logic [REP_W-1:0]     flashes_done;
    logic [LED_COUNT-1:0] target;
    logic                 correct;
    logic                 miss;
    logic                 correct_active;
    logic [CNT_W-1:0]     correct_elapsed;
    logic                 miss_active;
    logic [CNT_W-1:0]     miss_elapsed;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:            MODE_CHASE,
    effect_elapsed:  '0,
    flash_phase:     '0,
    effect_step:     '0,
    flashes_done:    '0,
    target:          '0,
    correct:         1'b0,
    miss:            1'b0,
    correct_active:  1'b0,
    correct_elapsed: '0,
    miss_active:     1'b0,
    miss_elapsed:    '0
  };

endpackage

`default_nettype wire

FILE: hw/rtl/les_step.sv
// les_step: next-state logic of the LED effect sequencer for one transaction.
// Depends on les_pkg (state, configuration and item types, codes).
`default_nettype none

module les_step (
  input  les_pkg::state_t cur,
  input  les_pkg::cfg_t   cfg,
  input  les_pkg::item_t  item,
  output les_pkg::state_t nxt
);
  import les_pkg::*;

  localparam int RECIP_SH = 14;
  localparam int RECIP    = (1 << RECIP_SH) / LED_COUNT;
  localparam int PROD_W   = NOTE_W + RECIP_SH;

  logic [PROD_W-1:0]    prod;
  logic [NOTE_W-1:0]    quo;
  logic [NOTE_W-1:0]    quo_mul;
  logic [NOTE_W-1:0]    rem_raw;
  logic [NOTE_W-1:0]    rem;
  logic [IDX_W-1:0]     note_idx;
  logic [LED_COUNT-1:0] note_bit;
  logic [CNT_W:0]       phase_inc;
  logic                 flash_on;
  state_t               s;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic state_t enter_mode(input state_t st, input logic [MODE_W-1:0] m);
    state_t r;
    r = st;
    if (m != st.mode) begin
      r.mode           = m;
      r.effect_elapsed = '0;
      r.flash_phase    = '0;
      r.effect_step    = '0;
      r.flashes_done   = '0;
      r.target         = '0;
      r.correct        = 1'b0;
      r.miss           = 1'b0;
    end
    enter_mode = r;
  endfunction

  // note mod LED_COUNT by reciprocal multiply and one correction
  always_comb begin
    prod     = PROD_W'(item.note_number) * PROD_W'(RECIP);
    quo      = prod[PROD_W-1 -: NOTE_W];
    quo_mul  = NOTE_W'(quo * NOTE_W'(LED_COUNT));
    rem_raw  = item.note_number - quo_mul;
    rem      = (rem_raw >= NOTE_W'(LED_COUNT)) ? rem_raw - NOTE_W'(LED_COUNT) : rem_raw;
    note_idx = rem[IDX_W-1:0];
    note_bit = LED_COUNT'(1) << note_idx;
  end

  always_comb begin
    s         = cur;
    phase_inc = '0;
    flash_on  = 1'b0;
    unique case (item.op)
      OP_TICK: begin
        s.effect_elapsed = sat_inc(s.effect_elapsed);
        if (s.correct_active) s.correct_elapsed = sat_inc(s.correct_elapsed);
        if (s.miss_active) s.miss_elapsed = sat_inc(s.miss_elapsed);
        unique case (s.mode)
          MODE_CHASE: begin
            if (s.effect_elapsed > cfg.chase_period_ms) begin
              s.correct        = 1'b0;
              s.miss           = 1'b0;
              s.effect_step    = (s.effect_step == STEP_W'(LED_COUNT - 1)) ?
                                 '0 : s.effect_step + 1'b1;
              s.target         = LED_COUNT'(1) << s.effect_step;
              s.effect_elapsed = '0;
            end
          end
          MODE_LOAD: begin
            if (s.effect_elapsed < cfg.load_flash_ms) begin
              if (s.effect_step == '0) begin
                s.target      = '1;
                s.correct     = 1'b1;
                s.miss        = 1'b1;
                s.effect_step = STEP_W'(1);
              end
            end else begin
              s = enter_mode(s, MODE_PLAY);
            end
          end
          MODE_END: begin
            phase_inc = {1'b0, s.flash_phase} + 1'b1;
            s.flash_phase = (phase_inc >= {1'b0, cfg.flash_period_ms}) ?
                            '0 : phase_inc[CNT_W-1:0];
            flash_on = s.flash_phase < cfg.flash_on_ms;
            if (s.flashes_done < cfg.flash_repeats) begin
              if ((flash_on && s.effect_step == '0) ||
                  (!flash_on && s.effect_step == STEP_W'(1))) begin
                s.target      = flash_on ? '1 : '0;
                s.correct     = flash_on;
                s.effect_step = flash_on ? STEP_W'(1) : '0;
                if (!flash_on) s.flashes_done = s.flashes_done + 1'b1;
              end
            end else begin
              s = enter_mode(s, MODE_PLAY);
            end
          end
          MODE_PLAY: begin
            if (s.correct_active && s.correct_elapsed >= cfg.pulse_ms) begin
              s.correct        = 1'b0;
              s.correct_active = 1'b0;
            end
            if (s.miss_active && s.miss_elapsed >= cfg.pulse_ms) begin
              s.miss        = 1'b0;
              s.miss_active = 1'b0;
            end
          end
          default: ;
        endcase
      end
      OP_MODE: s = enter_mode(s, item.new_mode);
      OP_NOTE: begin
        if (s.mode == MODE_PLAY) begin
          s.target = item.note_on ? (s.target | note_bit) : (s.target & ~note_bit);
        end
      end
      OP_CORRECT: begin
        if (s.mode == MODE_PLAY) begin
          s.correct         = 1'b1;
          s.correct_active  = 1'b1;
          s.correct_elapsed = '0;
        end
      end
      OP_MISS: begin
        if (s.mode == MODE_PLAY) begin
          s.miss         = 1'b1;
          s.miss_active  = 1'b1;
          s.miss_elapsed = '0;
        end
      end
      default: ;
    endcase
    nxt = s;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/led_effect_sequencer.sv
// led_effect_sequencer: top level with input register, state, result register.
// Depends on les_pkg and les_step.
//
// Input channel (in_*): one event per transaction: tick, mode change, note,
// correct trigger or miss trigger. Result channel (out_*): one transaction per
// event, showing LEDs and mode after that event. Both use valid/stall.
// Configuration: cfg_we writes cfg_wdata to register cfg_index;
// write only while no event is in flight.
// Path: an accepted event is held in the input register, goes through the
// les_step logic and lands in the result register once that register is
// empty or its waiting result is taken (out_stall low).
// Throughput: one event per cycle while no result is held back by out_stall.
// When out_stall is high with a result waiting, the held event stays in the
// input register and in_stall rises; nothing is lost or repeated.
// Reset (rst_n low, synchronous): both registers empty, idle chase mode,
// all LEDs off, pulses inactive, configuration at default values.
`default_nettype none

module led_effect_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [les_pkg::OP_W-1:0]         in_op,
  input  logic [les_pkg::MODE_W-1:0]       in_new_mode,
  input  logic [les_pkg::NOTE_W-1:0]       in_note_number,
  input  logic                             in_note_on,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [les_pkg::OUT_LEDS-1:0]     out_target_leds,
  output logic                             out_correct_led,
  output logic                             out_miss_led,
  output logic [les_pkg::MODE_W-1:0]       out_mode_now,
  input  logic                             cfg_we,
  input  logic [les_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [les_pkg::CFG_W-1:0]        cfg_wdata
);
  import les_pkg::*;

  logic                          s1_valid_r;
  item_t                         s1_item_r;
  state_t                        state_r;
  state_t                        state_nxt;
  cfg_t                          cfg_r;
  logic                          out_valid_r;
  logic [OUT_LEDS-1:0]           out_target_r;
  logic                          out_correct_r;
  logic                          out_miss_r;
  logic [MODE_W-1:0]             out_mode_r;
  logic [LED_COUNT+OUT_LEDS-1:0] target_ext;
  logic                          advance;
  logic                          in_take;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  les_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (s1_item_r),
    .nxt  (state_nxt)
  );

  assign target_ext = {{OUT_LEDS{1'b0}}, state_nxt.target};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chase_period_ms <= RST_CHASE_PERIOD;
      cfg_r.load_flash_ms   <= RST_LOAD_FLASH;
      cfg_r.flash_period_ms <= RST_FLASH_PERIOD;
      cfg_r.flash_on_ms     <= RST_FLASH_ON;
      cfg_r.flash_repeats   <= RST_FLASH_REPS;
      cfg_r.pulse_ms        <= RST_PULSE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHASE_PERIOD: cfg_r.chase_period_ms <= cfg_wdata;
        CFG_LOAD_FLASH:   cfg_r.load_flash_ms   <= cfg_wdata;
        CFG_FLASH_PERIOD: cfg_r.flash_period_ms <= cfg_wdata;
        CFG_FLASH_ON:     cfg_r.flash_on_ms     <= cfg_wdata;
        CFG_FLASH_REPS:   cfg_r.flash_repeats   <= cfg_wdata[REP_W-1:0];
        CFG_PULSE:        cfg_r.pulse_ms        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.op          <= in_op;
      s1_item_r.new_mode    <= in_new_mode;
      s1_item_r.note_number <= in_note_number;
      s1_item_r.note_on     <= in_note_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_target_r  <= target_ext[OUT_LEDS-1:0];
      out_correct_r <= state_nxt.correct;
      out_miss_r    <= state_nxt.miss;
      out_mode_r    <= state_nxt.mode;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_target_leds = out_target_r;
  assign out_correct_led = out_correct_r;
  assign out_miss_led    = out_miss_r;
  assign out_mode_now    = out_mode_r;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register empty after an advance");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.effect_step < STEP_W'(LED_COUNT))
    else $error("effect step out of range");

  a_phase_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode != MODE_END |-> state_r.flash_phase == '0)
    else $error("flash phase running outside end flash");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_led_effect_sequencer.sv
// tb_led_effect_sequencer: self-checking bench for led_effect_sequencer with a cycle-free
// behavioral predictor, random idling on both channels and a back-pressure stretch.
// Depends on les_pkg and the led_effect_sequencer RTL.
module tb_led_effect_sequencer;
  import les_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;
  localparam int              STALL_LIMIT = 1000;
  localparam int              RAND_ITEMS  = 350;

  typedef struct packed {
    logic [OUT_LEDS-1:0] leds;
    logic                correct;
    logic                miss;
    logic [MODE_W-1:0]   mode;
  } led_view_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = '0;
  logic [MODE_W-1:0]    in_new_mode = '0;
  logic [NOTE_W-1:0]    in_note_number = '0;
  logic                 in_note_on = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_LEDS-1:0]  out_target_leds;
  logic                 out_correct_led;
  logic                 out_miss_led;
  logic [MODE_W-1:0]    out_mode_now;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  led_effect_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_new_mode(in_new_mode),
    .in_note_number(in_note_number), .in_note_on(in_note_on),
    .out_valid(out_valid), .out_stall(out_stall), .out_target_leds(out_target_leds),
    .out_correct_led(out_correct_led), .out_miss_led(out_miss_led),
    .out_mode_now(out_mode_now),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  cfg_t                 seq_cfg;
  logic [MODE_W-1:0]    seq_mode;
  logic [CNT_W-1:0]     seq_elapsed;
  logic [CNT_W-1:0]     seq_phase;
  logic [STEP_W-1:0]    seq_step;
  logic [REP_W-1:0]     seq_blinks;
  logic [OUT_LEDS-1:0]  seq_leds;
  logic                 seq_correct;
  logic                 seq_miss;
  logic                 hit_active;
  logic [CNT_W-1:0]     hit_ms;
  logic                 miss_active;
  logic [CNT_W-1:0]     miss_ms;

  led_view_t            pending_views[$];
  int                   error_count = 0;
  int                   idle_cycles = 0;
  int                   hold_left = 0;
  int                   send_idle_pct = 18;
  int                   recv_idle_pct = 80;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic seq_clear_leds();
    seq_leds    = '0;
    seq_correct = 1'b0;
    seq_miss    = 1'b0;
  endtask

  task automatic seq_reset();
    seq_cfg.chase_period_ms = RST_CHASE_PERIOD;
    seq_cfg.load_flash_ms   = RST_LOAD_FLASH;
    seq_cfg.flash_period_ms = RST_FLASH_PERIOD;
    seq_cfg.flash_on_ms     = RST_FLASH_ON;
    seq_cfg.flash_repeats   = RST_FLASH_REPS;
    seq_cfg.pulse_ms        = RST_PULSE;
    seq_mode    = MODE_CHASE;
    seq_elapsed = '0;
    seq_phase   = '0;
    seq_step    = '0;
    seq_blinks  = '0;
    seq_clear_leds();
    hit_active  = 1'b0;
    hit_ms      = '0;
    miss_active = 1'b0;
    miss_ms     = '0;
  endtask

  task automatic seq_enter_mode(logic [MODE_W-1:0] m);
    if (m != seq_mode) begin
      seq_mode    = m;
      seq_elapsed = '0;
      seq_phase   = '0;
      seq_step    = '0;
      seq_blinks  = '0;
      seq_clear_leds();
    end
  endtask

  task automatic seq_tick();
    logic          lit;
    logic [CNT_W:0] ph;
    seq_elapsed = sat_up(seq_elapsed);
    if (hit_active) hit_ms = sat_up(hit_ms);
    if (miss_active) miss_ms = sat_up(miss_ms);
    case (seq_mode)
      MODE_CHASE: begin
        if (seq_elapsed > seq_cfg.chase_period_ms) begin
          seq_clear_leds();
          seq_step    = STEP_W'((int'(seq_step) + 1) % LED_COUNT);
          seq_leds    = OUT_LEDS'(1 << seq_step);
          seq_elapsed = '0;
        end
      end
      MODE_LOAD: begin
        if (seq_elapsed < seq_cfg.load_flash_ms) begin
          if (seq_step == 0) begin
            seq_leds    = '1;
            seq_correct = 1'b1;
            seq_miss    = 1'b1;
            seq_step    = 1;
          end
        end else begin
          seq_clear_leds();
          seq_enter_mode(MODE_PLAY);
        end
      end
      MODE_END: begin
        ph = {1'b0, seq_phase} + 1'b1;
        if (ph >= {1'b0, seq_cfg.flash_period_ms}) ph = '0;
        seq_phase = ph[CNT_W-1:0];
        if (seq_blinks < seq_cfg.flash_repeats) begin
          lit = seq_phase < seq_cfg.flash_on_ms;
          if ((lit && seq_step == 0) || (!lit && seq_step == 1)) begin
            seq_leds    = lit ? '1 : '0;
            seq_correct = lit;
            seq_step    = lit ? 1 : 0;
            if (!lit) seq_blinks = seq_blinks + 1'b1;
          end
        end else begin
          seq_clear_leds();
          seq_enter_mode(MODE_PLAY);
        end
      end
      default: begin
        if (hit_active && hit_ms >= seq_cfg.pulse_ms) begin
          seq_correct = 1'b0;
          hit_active  = 1'b0;
        end
        if (miss_active && miss_ms >= seq_cfg.pulse_ms) begin
          seq_miss    = 1'b0;
          miss_active = 1'b0;
        end
      end
    endcase
  endtask

  task automatic seq_apply_event(logic [OP_W-1:0] op, logic [MODE_W-1:0] nm,
                                 logic [NOTE_W-1:0] note, logic non);
    int idx;
    case (op)
      OP_TICK: seq_tick();
      OP_MODE: seq_enter_mode(nm);
      OP_NOTE: begin
        if (seq_mode == MODE_PLAY) begin
          idx = int'(note) % LED_COUNT;
          seq_leds[idx] = non;
        end
      end
      OP_CORRECT: begin
        if (seq_mode == MODE_PLAY) begin
          seq_correct = 1'b1;
          hit_active  = 1'b1;
          hit_ms      = '0;
        end
      end
      OP_MISS: begin
        if (seq_mode == MODE_PLAY) begin
          seq_miss    = 1'b1;
          miss_active = 1'b1;
          miss_ms     = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic seq_write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_CHASE_PERIOD: seq_cfg.chase_period_ms = data;
      CFG_LOAD_FLASH:   seq_cfg.load_flash_ms   = data;
      CFG_FLASH_PERIOD: seq_cfg.flash_period_ms = data;
      CFG_FLASH_ON:     seq_cfg.flash_on_ms     = data;
      CFG_FLASH_REPS:   seq_cfg.flash_repeats   = data[REP_W-1:0];
      CFG_PULSE:        seq_cfg.pulse_ms        = data;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("mismatch #%0d at %0t: %s got 0x%0h want 0x%0h", error_count, $realtime,
             what, got, want);
  endtask

  initial seq_reset();

  always @(posedge clk) begin : monitor
    led_view_t want;
    if (rst_n !== 1'b1) begin
      idle_cycles = 0;
    end else begin
      if (cfg_we === 1'b1) seq_write_reg(cfg_index, cfg_wdata);
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (pending_views.size() == 0) begin
          report_mismatch("unexpected transaction, leds", out_target_leds, 0);
        end else begin
          want = pending_views.pop_front();
          if (out_target_leds !== want.leds)
            report_mismatch("target_leds", out_target_leds, want.leds);
          if (out_correct_led !== want.correct)
            report_mismatch("correct_led", out_correct_led, want.correct);
          if (out_miss_led !== want.miss)
            report_mismatch("miss_led", out_miss_led, want.miss);
          if (out_mode_now !== want.mode)
            report_mismatch("mode_now", out_mode_now, want.mode);
        end
      end
      if (in_valid == 1'b1 && in_stall === 1'b0) begin
        seq_apply_event(in_op, in_new_mode, in_note_number, in_note_on);
        want = '{leds: seq_leds, correct: seq_correct, miss: seq_miss, mode: seq_mode};
        pending_views.push_back(want);
      end
      if ((out_valid === 1'b1 && out_stall == 1'b0) || (in_valid && in_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic send_event(logic [OP_W-1:0] op, logic [MODE_W-1:0] nm,
                            logic [NOTE_W-1:0] note, logic non);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_new_mode    <= nm;
    in_note_number <= note;
    in_note_on     <= non;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_event(OP_TICK, MODE_W'($urandom), NOTE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_mode(logic [MODE_W-1:0] m);
    send_event(OP_MODE, m, NOTE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_random_event();
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] nm;
    int                r;
    r  = $urandom_range(99);
    nm = MODE_W'($urandom);
    if (r < 45) op = OP_TICK;
    else if (r < 57) op = OP_MODE;
    else if (r < 75) op = OP_NOTE;
    else if (r < 85) op = OP_CORRECT;
    else if (r < 95) op = OP_MISS;
    else op = OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    if (op == OP_MODE && $urandom_range(2) == 0) nm = MODE_PLAY;
    send_event(op, nm, NOTE_W'($urandom), 1'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_word(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_config(cfg_t c);
    wait_idle();
    cfg_word(CFG_CHASE_PERIOD, c.chase_period_ms);
    cfg_word(CFG_LOAD_FLASH, c.load_flash_ms);
    cfg_word(CFG_FLASH_PERIOD, c.flash_period_ms);
    cfg_word(CFG_FLASH_ON, c.flash_on_ms);
    cfg_word(CFG_FLASH_REPS, CFG_W'(c.flash_repeats));
    cfg_word(CFG_PULSE, c.pulse_ms);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cfg_t make_config(int chase, int load, int period, int on_ms,
                                       int reps, int pulse);
    cfg_t c;
    c.chase_period_ms = CNT_W'(chase);
    c.load_flash_ms   = CNT_W'(load);
    c.flash_period_ms = CNT_W'(period);
    c.flash_on_ms     = CNT_W'(on_ms);
    c.flash_repeats   = REP_W'(reps);
    c.pulse_ms        = CNT_W'(pulse);
    return c;
  endfunction

  function automatic cfg_t random_config();
    int period;
    period = $urandom_range(10, 2);
    return make_config($urandom_range(6, 1), $urandom_range(12, 1), period,
                       $urandom_range(period + 1, 1), $urandom_range(4, 1),
                       $urandom_range(20, 1));
  endfunction

  task automatic test_power_on();
    send_event(OP_RSVD_LO, MODE_PLAY, '0, 1'b0);
    send_event(OP_NOTE, MODE_PLAY, 7'd5, 1'b1);
    send_event(OP_CORRECT, MODE_END, '1, 1'b1);
    send_event(OP_MISS, MODE_LOAD, '0, 1'b0);
    send_mode(MODE_CHASE);
    send_ticks(RST_CHASE_PERIOD + 2);
  endtask

  task automatic test_normal_events();
    write_config(make_config(RST_CHASE_PERIOD, RST_LOAD_FLASH, RST_FLASH_PERIOD,
                             RST_FLASH_ON, RST_FLASH_REPS, 3));
    send_mode(MODE_PLAY);
    send_event(OP_NOTE, MODE_CHASE, 7'd0, 1'b1);
    send_event(OP_NOTE, MODE_END, 7'd127, 1'b1);
    send_event(OP_NOTE, MODE_LOAD, 7'd11, 1'b1);
    send_event(OP_NOTE, MODE_PLAY, 7'd12, 1'b0);
    send_event(OP_NOTE, MODE_PLAY, 7'd64, 1'b1);
    send_event(OP_CORRECT, MODE_PLAY, '0, 1'b0);
    send_event(OP_MISS, MODE_PLAY, '1, 1'b1);
    send_ticks(2);
    send_event(OP_CORRECT, MODE_PLAY, '0, 1'b0);
    send_ticks(3);
    send_event(OP_RSVD_HI, MODE_END, '1, 1'b1);
    send_mode(MODE_PLAY);
    send_event(OP_MISS, MODE_PLAY, '0, 1'b0);
    send_mode(MODE_CHASE);
    send_ticks(2);
    send_mode(MODE_PLAY);
    send_ticks(2);
  endtask

  task automatic test_mode_effects();
    write_config(make_config(2, 3, 4, 2, 2, 5));
    send_mode(MODE_CHASE);
    send_ticks(7);
    send_mode(MODE_LOAD);
    send_ticks(4);
    send_event(OP_CORRECT, MODE_PLAY, '0, 1'b0);
    send_mode(MODE_END);
    send_event(OP_NOTE, MODE_END, 7'd3, 1'b1);
    send_ticks(10);
    send_mode(MODE_PLAY);
  endtask

  task automatic test_zero_registers();
    write_config(make_config(0, 0, 0, 1, 2, 0));
    send_mode(MODE_CHASE);
    send_ticks(3);
    send_mode(MODE_LOAD);
    send_ticks(1);
    send_event(OP_CORRECT, MODE_PLAY, '0, 1'b0);
    send_ticks(1);
    send_mode(MODE_END);
    send_ticks(3);
    send_mode(MODE_PLAY);
    write_config(make_config(1, 1, 1, 1, 0, 1));
    send_mode(MODE_END);
    send_ticks(2);
    write_config(make_config(1, 1, 1, 0, 1, 1));
    send_mode(MODE_END);
    send_ticks(3);
    send_mode(MODE_PLAY);
  endtask

  task automatic test_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_config(make_config(65535, 65535, 65535, 65535, 15, 65535));
    send_mode(MODE_PLAY);
    send_event(OP_NOTE, MODE_PLAY, 7'd127, 1'b1);
    send_event(OP_NOTE, MODE_PLAY, 7'd0, 1'b1);
    send_event(OP_NOTE, MODE_PLAY, 7'd127, 1'b0);
    send_event(OP_CORRECT, MODE_PLAY, '0, 1'b0);
    send_mode(MODE_CHASE);
    send_ticks(3);
    send_mode(MODE_END);
    send_ticks(3);
    send_mode(MODE_LOAD);
    send_ticks(4);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 18;
    write_config(random_config());
    hold_left = 48;
    repeat (16) send_random_event();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 80 : 0;
      recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 18 : 0;
      write_config(random_config());
      send_mode(MODE_PLAY);
      repeat (RAND_ITEMS) send_random_event();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_power_on();
    test_normal_events();
    test_mode_effects();
    test_zero_registers();
    test_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (4) @(posedge clk);
    if (pending_views.size() != 0)
      report_mismatch("transactions never returned", 0, pending_views.size());
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
